>>> rtl/erm_pkg.sv
// Shared types and constants for the echo range median filter.
// No dependencies; used by the core, and its payload types are carried on the stream interface.
`default_nettype none

package erm_pkg;

  // Window geometry
  localparam int unsigned WindowSize = 3;
  localparam int unsigned SlotW      = 2;

  // Field widths
  localparam int unsigned EchoW  = 14;
  localparam int unsigned DistW  = 15;
  localparam int unsigned TriesW = 4;
  localparam int unsigned CfgW   = 14;

  // Echo time to hundredths of a cm: (echo * 1756) >> 10
  localparam int unsigned ScaleW   = 11;
  localparam int unsigned ScaleK   = 1756;
  localparam int unsigned ScaleSh  = 10;
  localparam int unsigned ProductW = EchoW + ScaleW;

  // Register reset values
  localparam logic [TriesW-1:0] MaxTriesRst = TriesW'(3);
  localparam logic [EchoW-1:0]  TimeoutRst  = EchoW'(12000);

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_MAX_TRIES = 1'b0,
    CFG_TIMEOUT   = 1'b1
  } cfg_idx_e;

  // Request kinds
  typedef enum logic [0:0] {
    KIND_ATTEMPT = 1'b0,
    KIND_READ    = 1'b1
  } kind_e;

  // Channel payloads
  typedef struct packed {
    logic             kind;
    logic [EchoW-1:0] echo_us;
  } in_item_t;

  typedef struct packed {
    logic             reading_valid;
    logic [DistW-1:0] reading_centi_cm;
    logic             retry_wanted;
  } out_item_t;

endpackage

`default_nettype wire

>>> rtl/erm_stream_if.sv
// Valid/ready stream channel carrying one payload struct per transfer.
// Payload type is set per instance; typically erm_pkg::in_item_t or out_item_t.
`default_nettype none

interface erm_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/echo_range_median_filter_core.sv
// Echo range median filter core: two-stage pipeline with a three-slot window.
// Depends on erm_pkg and erm_stream_if.
//
// Usage:
//   in_i  (sink)   : one transfer per request. kind 0 carries an echo attempt
//                    (echo_us, 0 or above the timeout = no echo), kind 1 asks
//                    for the current filtered distance.
//   out_o (source) : exactly one result per request, in request order:
//                    reading_valid, reading_centi_cm and retry_wanted.
//   cfg_*          : write port; index 0 = max_tries, 1 = echo_timeout_us.
//                    Write only while no request is in flight.
// Timing: a request passes through the stage 1 register and then the output
//   register before it is valid on out_o; an out_o stall holds it in stage 1.
// Throughput: one request per cycle unless out_o stalls. Stage 1 registers
//   the echo scaling multiply and timeout compare; stage 2 updates the window
//   and counter; the output register takes the median, average or lone slot.
// Reset: window holds three valid zero slots, write slot and failure count
//   are zero, registers take max_tries = 3 and timeout = 12000 us.
// Stall: when out_o.ready is low the result holds in the output register;
//   stage 1 still takes one more request, then in_i.ready drops.
`default_nettype none

module echo_range_median_filter_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  erm_stream_if.sink                     in_i,
  erm_stream_if.source                   out_o,
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_idx_i,
  input  wire logic [erm_pkg::CfgW-1:0]  cfg_wdata_i
);

  localparam int unsigned DistW = erm_pkg::DistW;
  localparam int unsigned SlotW = erm_pkg::SlotW;
  localparam int unsigned TriesW = erm_pkg::TriesW;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(erm_pkg::WindowSize - 1);

  // Configuration registers
  logic [TriesW-1:0]        max_tries_q;
  logic [erm_pkg::EchoW-1:0] timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_tries_q <= erm_pkg::MaxTriesRst;
      timeout_q   <= erm_pkg::TimeoutRst;
    end else if (cfg_we_i) begin
      unique case (erm_pkg::cfg_idx_e'(cfg_idx_i))
        erm_pkg::CFG_MAX_TRIES: max_tries_q <= cfg_wdata_i[TriesW-1:0];
        erm_pkg::CFG_TIMEOUT:   timeout_q   <= cfg_wdata_i[erm_pkg::EchoW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake
  logic s1_valid_q;
  logic out_valid_q;
  logic advance;
  logic in_fire;
  logic s2_fire;

  assign advance     = !out_valid_q || out_o.ready;
  assign in_i.ready  = !s1_valid_q || advance;
  assign in_fire     = in_i.valid && in_i.ready;
  assign s2_fire     = s1_valid_q && advance;
  assign out_o.valid = out_valid_q;

  // Stage 1: echo check and scaling
  logic                           s1_attempt_q;
  logic                           s1_echo_ok_q;
  logic [DistW-1:0]               s1_dist_q;
  logic [erm_pkg::ProductW-1:0]   product;
  logic                           echo_ok;

  assign product = erm_pkg::ProductW'(in_i.data.echo_us) *
                   erm_pkg::ProductW'(erm_pkg::ScaleK);
  assign echo_ok = (in_i.data.echo_us != '0) && (in_i.data.echo_us <= timeout_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_attempt_q <= (erm_pkg::kind_e'(in_i.data.kind) == erm_pkg::KIND_ATTEMPT);
      s1_echo_ok_q <= echo_ok;
      s1_dist_q    <= product[erm_pkg::ScaleSh +: DistW];
    end
  end

  // Stage 2: window update
  logic [DistW-1:0]  win_q [erm_pkg::WindowSize];
  logic [DistW-1:0]  win_d [erm_pkg::WindowSize];
  logic [erm_pkg::WindowSize-1:0] vld_q, vld_d;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic [TriesW-1:0] cnt_q, cnt_d, cnt_inc;
  logic              retry_d;
  logic              store;
  logic [DistW-1:0]  store_dist;

  always_comb begin
    cnt_inc    = cnt_q + TriesW'(1);
    cnt_d      = cnt_q;
    retry_d    = 1'b0;
    store      = 1'b0;
    store_dist = s1_dist_q;
    if (s1_attempt_q) begin
      if (s1_echo_ok_q) begin
        store = 1'b1;
        cnt_d = '0;
      end else if (cnt_inc >= max_tries_q) begin
        // failure limit: store an invalid slot
        store      = 1'b1;
        store_dist = '0;
        cnt_d      = '0;
      end else begin
        cnt_d   = cnt_inc;
        retry_d = 1'b1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < erm_pkg::WindowSize; i++) begin
      win_d[i] = win_q[i];
    end
    vld_d  = vld_q;
    slot_d = slot_q;
    if (store) begin
      win_d[slot_q] = store_dist;
      vld_d[slot_q] = s1_echo_ok_q;
      slot_d        = (slot_q == LastSlot) ? '0 : slot_q + SlotW'(1);
    end
  end

  // Filtered reading of the updated window
  logic [DistW-1:0] lo01, hi01, mid, avg;
  logic [DistW:0]   pair_sum;
  logic [DistW-1:0] pair_a, pair_b;
  erm_pkg::out_item_t res_d;

  always_comb begin
    lo01 = (win_d[0] < win_d[1]) ? win_d[0] : win_d[1];
    hi01 = (win_d[0] < win_d[1]) ? win_d[1] : win_d[0];
    mid  = (hi01 < win_d[2]) ? hi01 : win_d[2];
    if (lo01 > mid) mid = lo01;

    // pick the two valid slots for the two-sample average
    pair_a = vld_d[0] ? win_d[0] : win_d[1];
    pair_b = vld_d[2] ? win_d[2] : win_d[1];
    pair_sum = {1'b0, pair_a} + {1'b0, pair_b};
    avg      = pair_sum[DistW:1];

    res_d.retry_wanted  = retry_d;
    res_d.reading_valid = (vld_d != '0);
    unique case (vld_d)
      3'b000:                  res_d.reading_centi_cm = '0;
      3'b001:                  res_d.reading_centi_cm = win_d[0];
      3'b010:                  res_d.reading_centi_cm = win_d[1];
      3'b100:                  res_d.reading_centi_cm = win_d[2];
      3'b011, 3'b101, 3'b110:  res_d.reading_centi_cm = avg;
      3'b111:                  res_d.reading_centi_cm = mid;
      default:                 res_d.reading_centi_cm = '0;
    endcase
  end

  // State and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < erm_pkg::WindowSize; i++) begin
        win_q[i] <= '0;
      end
      vld_q       <= '1;
      slot_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s2_fire) begin
        for (int i = 0; i < erm_pkg::WindowSize; i++) begin
          win_q[i] <= win_d[i];
        end
        vld_q  <= vld_d;
        slot_q <= slot_d;
        cnt_q  <= cnt_d;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  erm_pkg::out_item_t res_q;

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      res_q <= res_d;
    end
  end

  assign out_o.data = res_q;

`ifndef SYNTHESIS
  // a processed request always lands in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni) s2_fire |=> out_valid_q)
    else $error("result lost after stage 2");

  // an invalid reading carries a zero distance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_q && !res_q.reading_valid) |-> (res_q.reading_centi_cm == '0))
    else $error("invalid reading with nonzero distance");

  // a retry request leaves a pending failure count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (s2_fire && retry_d) |=> (cnt_q != '0))
    else $error("retry without pending failure");

  // a good echo clears the failure count and is stored valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (s2_fire && s1_attempt_q && s1_echo_ok_q) |=> (cnt_q == '0 && vld_q != '0))
    else $error("good echo did not reset failure count");

  // the write slot stays inside the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      s2_fire |=> (slot_q <= LastSlot))
    else $error("write slot out of range");
`endif

endmodule

`default_nettype wire
